FILE: hw/rtl/nsqrt_pkg.sv
package nsqrt_pkg;

  localparam int unsigned MaxSteps = 20;
  localparam int unsigned StepW = $clog2(MaxSteps + 1);
  localparam int unsigned DivBits = 56;
  localparam int unsigned DivCntW = $clog2(DivBits);

  localparam logic [63:0] BitsPosInf = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] BitsQnan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] BitsQuiet = 64'h0008_0000_0000_0000;
  localparam logic [63:0] BitsOne = 64'h3FF0_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DNORM,
    S_DIV,
    S_PNORM,
    S_PRND,
    S_ADD,
    S_HALF,
    S_DONE
  } state_e;

  // what the shared pack unit is finishing
  typedef enum logic [1:0] {
    PH_INIT,
    PH_DIV,
    PH_ADD,
    PH_HALF
  } phase_e;

  typedef struct packed {
    logic [52:0]        m;
    logic signed [13:0] e;
  } unp_t;

  // value = m * 2^e, hidden bit made explicit
  function automatic unp_t unpack(input logic [63:0] b);
    unp_t u;
    if (b[62:52] == 11'd0) begin
      u.m = {1'b0, b[51:0]};
      u.e = -14'sd1074;
    end else begin
      u.m = {1'b1, b[51:0]};
      u.e = $signed({3'b000, b[62:52]}) - 14'sd1075;
    end
    return u;
  endfunction

endpackage

FILE: hw/rtl/newton_square_root_double_top.sv
// Square root of one IEEE-754 double by Newton steps g <= (g + x/g)/2, starting at x/2,
// round to nearest even with subnormals kept, up to 20 steps with early stop when the
// guess holds. A transaction starts when start is high and busy is low; the result shows
// on root_bits_o for one cycle with valid_o high and cannot be stalled. Special operands
// (NaN, infinity, negative, zero, one) finish without any Newton step. Otherwise each step runs
// a restoring divider, then one shared normalize and round unit that runs on the initial
// guess x/2 and after the divide, the add and the halving, shifting 8 or 1 bits a cycle.
module newton_square_root_double_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] x_bits_i,
  output logic        valid_o,
  output logic [63:0] root_bits_o
);
  import nsqrt_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q;

  logic [63:0] x_q, g_q, t_q, root_q;
  logic [StepW-1:0] step_q;

  // divider
  logic [52:0] dx_q, dg_q;
  logic signed [13:0] dxe_q, dge_q;
  logic [54:0] rem_q;
  logic [DivBits-2:0] quot_q;
  logic [DivCntW-1:0] dcnt_q;

  // pack unit
  logic [63:0] pm_q;
  logic signed [13:0] pe_q;
  logic ps_q;

  unp_t ux, ug, ut;
  assign ux = unpack(x_q);
  assign ug = unpack(g_q);
  assign ut = unpack(t_q);

  logic x_special;
  logic [63:0] x_special_res;
  always_comb begin
    x_special = 1'b1;
    x_special_res = x_bits_i;
    if (x_bits_i[62:52] == 11'h7FF) begin
      if (x_bits_i[51:0] != 52'd0) x_special_res = x_bits_i | BitsQuiet;
      else if (x_bits_i[63]) x_special_res = 64'd0;
      else x_special_res = BitsQnan;
    end else if (x_bits_i[62:0] == 63'd0) begin
      x_special_res = x_bits_i;
    end else if (x_bits_i[63]) begin
      x_special_res = 64'd0;
    end else if (x_bits_i == BitsOne) begin
      x_special_res = x_bits_i;
    end else begin
      x_special = 1'b0;
    end
  end

  logic dnorm_done;
  assign dnorm_done = dx_q[52] & dg_q[52];

  logic rem_ge;
  logic [54:0] rem_sub;
  assign rem_ge = rem_q >= {2'b00, dg_q};
  assign rem_sub = rem_q - {2'b00, dg_q};

  // alignment for the add of g and t
  logic [52:0] add_ma, add_mb;
  logic signed [13:0] add_ea, add_eb;
  logic [13:0] add_d;
  logic [63:0] add_bw, add_bs, add_sum;
  logic add_st;
  always_comb begin
    if (ug.e >= ut.e) begin
      add_ma = ug.m; add_ea = ug.e; add_mb = ut.m; add_eb = ut.e;
    end else begin
      add_ma = ut.m; add_ea = ut.e; add_mb = ug.m; add_eb = ug.e;
    end
    add_d = 14'(add_ea - add_eb);
    add_bw = {1'b0, add_mb, 10'd0};
    if (add_d >= 14'd64) begin
      add_bs = 64'd0;
      add_st = |add_bw;
    end else begin
      add_bs = add_bw >> add_d[5:0];
      add_st = |(add_bw & ((64'd1 << add_d[5:0]) - 64'd1));
    end
    add_sum = {1'b0, add_ma, 10'd0} + add_bs;
  end

  // round and pack, pm_q normalized with bit 63 set
  logic signed [13:0] rnd_exp;
  logic [6:0] rnd_sh;
  logic [10:0] rnd_eeff;
  logic [63:0] rnd_shifted;
  logic rnd_lost, rnd_st, rnd_inc, rnd_ovf;
  logic [52:0] rnd_keep;
  logic [53:0] rnd_m;
  logic [63:0] rnd_res;
  always_comb begin
    rnd_exp = pe_q + 14'sd1086;
    rnd_ovf = 1'b0;
    rnd_sh = 7'd0;
    rnd_eeff = 11'd1;
    if (rnd_exp >= 14'sd1) begin
      if (rnd_exp > 14'sd2046) rnd_ovf = 1'b1;
      else rnd_eeff = rnd_exp[10:0];
    end else if (rnd_exp < -14'sd62) begin
      rnd_sh = 7'd64;
    end else begin
      rnd_sh = 7'(14'sd1 - rnd_exp);
    end
    if (rnd_sh[6]) begin
      rnd_shifted = 64'd0;
      rnd_lost = |pm_q;
    end else begin
      rnd_shifted = pm_q >> rnd_sh[5:0];
      rnd_lost = |(pm_q & ((64'd1 << rnd_sh[5:0]) - 64'd1));
    end
    rnd_keep = rnd_shifted[63:11];
    rnd_st = (|rnd_shifted[9:0]) | rnd_lost | ps_q;
    rnd_inc = rnd_shifted[10] & (rnd_st | rnd_keep[0]);
    rnd_m = {1'b0, rnd_keep} + {53'd0, rnd_inc};
    rnd_res = {1'b0, 11'(rnd_eeff - 11'd1), 52'd0} + {10'd0, rnd_m};
    if (rnd_ovf) rnd_res = BitsPosInf;
  end

  unp_t ur;
  assign ur = unpack(rnd_res);

  logic last_step;
  assign last_step = (rnd_res == g_q) || (step_q == StepW'(MaxSteps - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = x_special ? S_DONE : S_PNORM;
      S_DNORM: if (dnorm_done) state_d = S_DIV;
      S_DIV:   if (dcnt_q == DivCntW'(DivBits - 1)) state_d = S_PNORM;
      S_PNORM: if (pm_q[63] || pm_q == 64'd0) state_d = S_PRND;
      S_PRND: begin
        case (phase_q)
          PH_INIT: state_d = (rnd_res == 64'd0) ? S_DONE : S_DNORM;
          PH_DIV:  state_d = S_ADD;
          PH_ADD:  state_d = S_HALF;
          PH_HALF: state_d = last_step ? S_DONE : S_DNORM;
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD:   state_d = S_PNORM;
      S_HALF:  state_d = S_PNORM;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy = state_q != S_IDLE;
    valid_o = state_q == S_DONE;
    root_bits_o = root_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_INIT;
      step_q <= '0;
      dcnt_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          phase_q <= PH_INIT;
          step_q <= '0;
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + DivCntW'(1);
          if (dcnt_q == DivCntW'(DivBits - 1)) phase_q <= PH_DIV;
        end
        S_DNORM: dcnt_q <= '0;
        S_ADD: phase_q <= PH_ADD;
        S_HALF: phase_q <= PH_HALF;
        S_PRND: if (phase_q == PH_HALF) step_q <= step_q + StepW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q <= x_bits_i;
        root_q <= x_special_res;
        // initial guess x/2
        pm_q <= {11'd0, x_bits_i[62:52] == 11'd0 ? 1'b0 : 1'b1, x_bits_i[51:0]};
        pe_q <= (x_bits_i[62:52] == 11'd0) ? -14'sd1075
              : $signed({3'b000, x_bits_i[62:52]}) - 14'sd1076;
        ps_q <= 1'b0;
      end
      S_DNORM: begin
        if (!dx_q[52]) begin
          if (dx_q[52:45] == 8'd0) begin
            dx_q <= dx_q << 8; dxe_q <= dxe_q - 14'sd8;
          end else begin
            dx_q <= dx_q << 1; dxe_q <= dxe_q - 14'sd1;
          end
        end
        if (!dg_q[52]) begin
          if (dg_q[52:45] == 8'd0) begin
            dg_q <= dg_q << 8; dge_q <= dge_q - 14'sd8;
          end else begin
            dg_q <= dg_q << 1; dge_q <= dge_q - 14'sd1;
          end
        end
        rem_q <= {2'b00, dx_q};
      end
      S_DIV: begin
        quot_q <= {quot_q[DivBits-3:0], rem_ge};
        rem_q <= rem_ge ? (rem_sub << 1) : (rem_q << 1);
        if (dcnt_q == DivCntW'(DivBits - 1)) begin
          pm_q <= {8'd0, quot_q, rem_ge};
          pe_q <= dxe_q - dge_q - 14'sd55;
          ps_q <= rem_ge ? (rem_sub != 55'd0) : (rem_q != 55'd0);
        end
      end
      S_PNORM: begin
        if (!pm_q[63] && pm_q != 64'd0) begin
          if (pm_q[63:56] == 8'd0) begin
            pm_q <= pm_q << 8; pe_q <= pe_q - 14'sd8;
          end else begin
            pm_q <= pm_q << 1; pe_q <= pe_q - 14'sd1;
          end
        end
      end
      S_PRND: begin
        case (phase_q)
          PH_INIT: begin
            g_q <= rnd_res;
            root_q <= BitsPosInf;
            dx_q <= ux.m; dxe_q <= ux.e;
            dg_q <= ur.m; dge_q <= ur.e;
          end
          PH_DIV, PH_ADD: t_q <= rnd_res;
          PH_HALF: begin
            g_q <= rnd_res;
            root_q <= rnd_res;
            dx_q <= ux.m; dxe_q <= ux.e;
            dg_q <= ur.m; dge_q <= ur.e;
          end
          default: ;
        endcase
      end
      S_ADD: begin
        pm_q <= add_sum;
        pe_q <= add_ea - 14'sd10;
        ps_q <= add_st;
      end
      S_HALF: begin
        pm_q <= {11'd0, ut.m};
        pe_q <= ut.e - 14'sd1;
        ps_q <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsqrt_pkg::*;

  localparam int unsigned NumRandom = 480;
  localparam longint unsigned CycleLimit = 6_000_000;
  localparam logic [63:0] ExpMask = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FracMask = 64'h000F_FFFF_FFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] x_bits_i;
  logic        valid_o;
  logic [63:0] root_bits_o;

  logic [63:0] root_q[$];
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_special;
  longint unsigned cycles;
  bit          no_idle;

  newton_square_root_double_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .x_bits_i   (x_bits_i),
    .valid_o    (valid_o),
    .root_bits_o(root_bits_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // host real arithmetic is ieee double with round to nearest even
  function automatic logic [63:0] newton_root_of(input logic [63:0] xb);
    real x;
    real g;
    real p;
    if ((xb & ExpMask) == ExpMask) begin
      if ((xb & FracMask) != 0) return xb | BitsQuiet;
      if (xb[63]) return 64'd0;
      return BitsQnan;
    end
    x = $bitstoreal(xb);
    if (x < 0.0) return 64'd0;
    if (x == 0.0 || x == 1.0) return xb;
    g = x / 2.0;
    if (g == 0.0) return BitsPosInf;
    for (int i = 0; i < MaxSteps; i++) begin
      p = g;
      g = (g + x / g) / 2.0;
      if (g == p) break;
    end
    return $realtobits(g);
  endfunction

  task automatic send_operand(input logic [63:0] xb);
    if (!no_idle) begin
      while ($urandom_range(99) < 12) begin
        start <= 1'b0;
        x_bits_i <= {$urandom, $urandom};
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    x_bits_i <= xb;
    do @(posedge clk_i); while (busy);
    root_q.push_back(newton_root_of(xb));
    n_sent++;
    if ((xb & ExpMask) == ExpMask || xb[63] || xb == 64'd0 || xb == BitsOne) n_special++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (root_q.size() == 0) begin
        $error("unexpected transaction: root_bits got %h", root_bits_o);
        n_errors++;
      end else begin
        if (root_bits_o !== root_q[0]) begin
          $error("root_bits mismatch: expected %h actual %h", root_q[0], root_bits_o);
          n_errors++;
        end
        void'(root_q.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_special_operands();
    send_operand(64'h0000_0000_0000_0000);
    send_operand(64'h8000_0000_0000_0000);
    send_operand(BitsOne);
    send_operand(64'hBFF0_0000_0000_0000);
    send_operand(BitsPosInf);
    send_operand(64'hFFF0_0000_0000_0000);
    send_operand(BitsQnan);
    send_operand(64'h7FF0_0000_0000_0001);
    send_operand(64'hFFF5_5555_AAAA_AAAA);
    send_operand(64'hC000_0000_0000_0000);
  endtask

  task automatic test_extremes();
    send_operand(64'h0000_0000_0000_0001);  // half of it rounds to zero
    send_operand(64'h0000_0000_0000_0002);
    send_operand(64'h000F_FFFF_FFFF_FFFF);
    send_operand(64'h0010_0000_0000_0000);
    send_operand(64'h7FEF_FFFF_FFFF_FFFF);  // too large to converge in time
    send_operand(64'h4010_0000_0000_0000);
    send_operand(64'h4000_0000_0000_0000);
    send_operand(64'h3FD0_0000_0000_0000);
    send_operand(64'h3FEF_FFFF_FFFF_FFFF);
    send_operand(64'h3FF0_0000_0000_0001);
    send_operand(64'h7E37_E43C_8800_759C);
    send_operand(64'h8000_0000_0000_0001);
  endtask

  task automatic test_random_operands();
    logic [63:0] xb;
    for (int i = 0; i < NumRandom; i++) begin
      no_idle = (i >= 150 && i < 230);
      xb = {$urandom, $urandom};
      case ($urandom_range(9))
        0, 1:    ;  // fully random pattern
        2:       xb[62:52] = 11'd0;  // subnormal
        3:       xb[62:52] = $urandom_range(1) ? 11'h7FF : 11'h7FE;
        default: begin
          xb[63] = 1'b0;
          xb[62:52] = 11'(1023 + $urandom_range(120) - 60);
        end
      endcase
      send_operand(xb);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    x_bits_i = 64'd0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    n_special = 0;
    cycles = 0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_operands();
    test_extremes();
    test_random_operands();
    start <= 1'b0;
    while (root_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d operands (%0d special: nan, inf, negative, zero, one), checked %0d roots",
             n_sent, n_special, n_checked);
    $display("covered subnormals, extremes and random patterns over %0d cycles", cycles);
    if (n_errors == 0 && root_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/nsqrt_pkg.sv
hw/rtl/newton_square_root_double_top.sv
bench/testbench.sv
